/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hw/rtl/fri_pkg.sv */
// Package with constants and types of the fuzzy rule inference unit.
`default_nettype none
package fri_pkg;
    localparam int MaxRules   = 64;
    localparam int Variables  = 4;
    localparam int Regions    = 5;
    localparam int OutputSets = 9;
    localparam int MfCount    = Variables * Regions;
    localparam int RuleAw     = $clog2(MaxRules);
    localparam int MfAw       = $clog2(MfCount);
    localparam int OsAw       = 4;
    localparam logic [16:0] DegOne = 17'd32768;

    localparam logic [1:0] KIND_EVAL  = 2'd0;
    localparam logic [1:0] KIND_RULE  = 2'd1;
    localparam logic [1:0] KIND_TRAP  = 2'd2;
    localparam logic [1:0] KIND_LEVEL = 2'd3;

    localparam logic [1:0] SHAPE_LEFT  = 2'd0;
    localparam logic [1:0] SHAPE_RIGHT = 2'd1;
    localparam logic [1:0] SHAPE_REG   = 2'd2;

    localparam logic CFG_RULE_COUNT   = 1'b0;
    localparam logic CFG_WEIGHT_FLOOR = 1'b1;

    // Control from the sequencer to the divider.
    typedef struct packed {
        logic        start;
        logic [36:0] dividend_mag;
        logic [21:0] divisor;
        logic        negative;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [15:0] value;
    } t_div_rsp;
endpackage
`default_nettype wire

/* hw/rtl/fri_divider.sv */
// Restoring divider, one quotient bit per cycle, with signed saturation.
`default_nettype none
`include "assert_macros.svh"
module fri_divider (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  fri_pkg::t_div_req i_req,
    output fri_pkg::t_div_rsp o_rsp
);
    import fri_pkg::*;

    logic [36:0] r_quo, n_quo;
    logic [22:0] r_rem, n_rem;
    logic [21:0] r_den;
    logic        r_neg;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, r_done;
    logic [22:0] w_trial;
    logic [37:0] w_sq;
    logic [15:0] w_sat;

    always_comb begin
        w_trial = {r_rem[21:0], r_quo[36]};
        n_quo = {r_quo[35:0], 1'b0};
        n_rem = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = w_trial - {1'b0, r_den};
            n_quo[0] = 1'b1;
        end
        n_cnt = r_cnt - 6'd1;
    end

    // Saturate the magnitude and apply the sign (truncation toward zero).
    always_comb begin
        w_sq = r_neg ? -{1'b0, r_quo} : {1'b0, r_quo};
        if (!r_neg && r_quo > 37'd32767) w_sat = 16'h7fff;
        else if (r_neg && r_quo > 37'd32768) w_sat = 16'h8000;
        else w_sat = w_sq[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd37;
            end else if (r_busy) begin
                r_cnt <= n_cnt;
                if (n_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend_mag;
            r_rem <= '0;
            r_den <= i_req.divisor;
            r_neg <= i_req.negative;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = w_sat;

    `ASSERT_NEXT(a_div_done_once, i_clk, i_rst_n, r_done, !r_done)
    `ASSERT_IMP(a_div_no_restart, i_clk, i_rst_n, r_busy, !i_req.start)
    `ASSERT_IMP(a_div_rem_bound, i_clk, i_rst_n, r_busy, r_rem < {1'b0, r_den})
endmodule
`default_nettype wire

/* hw/rtl/fuzzy_rule_inference_unit.sv */
// Top level of the fuzzy rule inference unit: tables, rule sequencer, divider.
//
// Usage. Items enter on the command channel: start is taken at a rising
// edge while busy is low. Kind 1 loads a rule entry, kind 2 a trapezoid
// membership function, kind 3 an output level; loads give
// no result. Kind 0 evaluates four Q8.8 samples and gives one result, shown
// on o_control_value and o_no_rule_fired for exactly one cycle with
// o_result_valid high. The receiver cannot stall; it must take the result in
// that cycle.
// An evaluation over n = min(rule_count, 64) rules passes, per rule, through
// an entry read, then per antecedent a membership read, classification,
// edge multiply and fold; then an end-of-rules step, a divider start step
// and the 37-step bit-serial divider. When the weight sum is zero or below
// the weight floor the divider is skipped. The shared edge multiplier and
// the radix-2 divider set the evaluation time. busy is high for the whole
// evaluation, so one evaluation ends before the next.
// Configuration writes use i_cfg_valid / o_cfg_ready with an index and data
// and are meant only while the block is idle. Reset sets rule_count to 0 and
// weight_floor to 1; the tables hold nothing defined until loaded.
`default_nettype none
`include "assert_macros.svh"
module fuzzy_rule_inference_unit (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire  [1:0]         i_kind,
    input  wire  [5:0]         i_slot,
    input  wire  signed [15:0] i_sample_or_corner_a,
    input  wire  signed [15:0] i_sample_or_corner_b,
    input  wire  signed [15:0] i_sample_or_corner_c,
    input  wire  signed [15:0] i_sample_or_corner_d,
    input  wire  [1:0]         i_shape_type,
    input  wire  signed [23:0] i_left_slope,
    input  wire  signed [23:0] i_right_slope,
    input  wire  [13:0]        i_rule_entry,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire  [0:0]         i_cfg_index,
    input  wire  [21:0]        i_cfg_data,
    output logic               o_result_valid,
    output logic signed [15:0] o_control_value,
    output logic               o_no_rule_fired
);
    import fri_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RULE = 3'd1;
    localparam logic [2:0] ST_MF   = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_WAIT = 3'd6;
    localparam logic [2:0] ST_QUOT = 3'd7;

    // Configuration registers.
    logic [6:0]  r_rule_count;
    logic [21:0] r_weight_floor;

    // Tables, all written and read in clocked blocks.
    logic [13:0]        m_rule  [MaxRules];
    logic [63:0]        m_corner[MfCount];
    logic [47:0]        m_slope [MfCount];
    logic [1:0]         m_shape [MfCount];
    logic signed [15:0] m_level [OutputSets];

    logic [2:0]  r_state;
    logic [6:0]  r_idx, r_n;
    logic        r_ant;               // which antecedent is being evaluated
    logic signed [15:0] r_samp[Variables];
    logic [13:0] r_entry;
    logic [63:0] r_crn;
    logic [47:0] r_slp;
    logic [1:0]  r_shp;
    logic        r_ant_ok;
    logic signed [15:0] r_x;
    logic [16:0] r_deg0, r_deg_fix;
    logic        r_use_mul;
    logic signed [23:0] r_mslope;
    logic signed [16:0] r_mdx;
    logic signed [40:0] r_prod;
    logic signed [15:0] r_lvl;
    logic [22:0] r_wsum;
    logic signed [39:0] r_lsum;
    logic        r_res_valid, r_res_empty;
    logic [15:0] r_res_value;

    t_div_req w_req;
    t_div_rsp w_rsp;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule_count   <= 7'd0;
            r_weight_floor <= 22'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RULE_COUNT:   r_rule_count   <= i_cfg_data[6:0];
                CFG_WEIGHT_FLOOR: r_weight_floor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Table loads.
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            if (i_kind == KIND_RULE && {1'b0, i_slot} < 7'(MaxRules))
                m_rule[i_slot[RuleAw-1:0]] <= i_rule_entry;
            if (i_kind == KIND_TRAP && i_slot < 6'(MfCount)) begin
                m_corner[i_slot[MfAw-1:0]] <= {i_sample_or_corner_d, i_sample_or_corner_c,
                                               i_sample_or_corner_b, i_sample_or_corner_a};
                m_slope[i_slot[MfAw-1:0]]  <= {i_right_slope, i_left_slope};
                m_shape[i_slot[MfAw-1:0]]  <= i_shape_type;
            end
            if (i_kind == KIND_LEVEL && i_slot < 6'(OutputSets))
                m_level[i_slot[OsAw-1:0]] <= i_sample_or_corner_a;
        end
    end

    // Antecedent fields and output set of the current entry.
    logic [1:0] w_var;
    logic [2:0] w_set;
    logic [4:0] w_mf;
    logic [3:0] w_os;
    always_comb begin
        w_var = r_ant ? r_entry[6:5] : r_entry[1:0];
        w_set = r_ant ? r_entry[9:7] : r_entry[4:2];
        w_mf  = 5'(w_var) * 5'(Regions) + 5'(w_set);
        w_os  = r_entry[13:10];
    end

    // Membership classification: either a fixed degree or a slope product.
    logic signed [15:0] w_a, w_b, w_c, w_d;
    logic signed [23:0] w_ls, w_rs;
    logic [16:0] w_fix;
    logic        w_mul;
    logic signed [23:0] w_ms;
    logic signed [16:0] w_dx;
    always_comb begin
        w_a = r_crn[15:0];  w_b = r_crn[31:16];
        w_c = r_crn[47:32]; w_d = r_crn[63:48];
        w_ls = r_slp[23:0]; w_rs = r_slp[47:24];
        w_fix = '0; w_mul = 1'b0; w_ms = w_ls; w_dx = '0;
        if (r_ant_ok) begin
            case (r_shp)
                SHAPE_LEFT: begin
                    if (r_x <= w_a) w_fix = DegOne;
                    else if (r_x < w_b) begin
                        w_mul = 1'b1; w_ms = w_rs; w_dx = 17'(r_x) - 17'(w_b);
                    end
                end
                SHAPE_RIGHT: begin
                    if (r_x >= w_b && r_x > w_a) w_fix = DegOne;
                    else if (r_x > w_a) begin
                        w_mul = 1'b1; w_dx = 17'(r_x) - 17'(w_a);
                    end
                end
                SHAPE_REG: begin
                    if (r_x <= w_a || r_x >= w_d) w_fix = '0;
                    else if (r_x >= w_b && r_x <= w_c) w_fix = DegOne;
                    else if (r_x <= w_b) begin
                        w_mul = 1'b1; w_dx = 17'(r_x) - 17'(w_a);
                    end else if (r_x >= w_c) begin
                        w_mul = 1'b1; w_ms = w_rs; w_dx = 17'(r_x) - 17'(w_d);
                    end
                end
                default: ;
            endcase
        end
    end

    // Edge degree from the registered product: floor divide by 256, clamp; then the minimum with the first degree.
    logic signed [32:0] w_q;
    logic [16:0] w_edge, w_deg, w_w;
    always_comb begin
        w_q = r_prod[40:8];
        if (w_q < 0) w_edge = '0;
        else if (w_q > 33'sd32768) w_edge = DegOne;
        else w_edge = w_q[16:0];
        w_deg = r_use_mul ? w_edge : r_deg_fix;
        w_w = (w_deg < r_deg0) ? w_deg : r_deg0;
    end

    // Division request. The level sum can reach 2^36 in magnitude.
    logic signed [39:0] w_lmag;
    always_comb begin
        w_lmag = r_lsum[39] ? -r_lsum : r_lsum;
        w_req.start        = (r_state == ST_DIV) &&
                             !(r_wsum == 0 || r_wsum < {1'b0, r_weight_floor});
        w_req.dividend_mag = w_lmag[36:0];
        w_req.divisor      = r_wsum[21:0];
        w_req.negative     = r_lsum[39];
    end

    fri_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    // Sequencer: per rule, fetch entry, then per antecedent fetch the
    // membership, classify, multiply, and fold into the weight; then accumulate and divide.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (start && i_kind == KIND_EVAL) begin
                        r_samp[0] <= i_sample_or_corner_a;
                        r_samp[1] <= i_sample_or_corner_b;
                        r_samp[2] <= i_sample_or_corner_c;
                        r_samp[3] <= i_sample_or_corner_d;
                        r_n    <= (r_rule_count > 7'(MaxRules)) ? 7'(MaxRules) : r_rule_count;
                        r_idx  <= '0;
                        r_wsum <= '0;
                        r_lsum <= '0;
                        r_state <= ST_RULE;
                    end
                end
                ST_RULE: begin
                    if (r_idx == r_n) r_state <= ST_DIV;
                    else begin
                        r_entry <= m_rule[r_idx[RuleAw-1:0]];
                        r_ant   <= 1'b0;
                        r_state <= ST_MF;
                    end
                end
                ST_MF: begin
                    r_crn    <= m_corner[w_mf < 5'(MfCount) ? w_mf : 5'd0];
                    r_slp    <= m_slope[w_mf < 5'(MfCount) ? w_mf : 5'd0];
                    r_shp    <= m_shape[w_mf < 5'(MfCount) ? w_mf : 5'd0];
                    r_ant_ok <= (w_set < 3'(Regions));
                    r_x      <= r_samp[w_var];
                    r_state  <= ST_MUL;
                end
                ST_MUL: begin
                    r_use_mul <= w_mul;
                    r_deg_fix <= w_fix;
                    r_mslope  <= w_ms;
                    r_mdx     <= w_dx;
                    r_state   <= ST_ACC;
                end
                ST_ACC: begin
                    // The product registered here is used in ST_WAIT.
                    r_prod <= 41'(r_mslope * r_mdx);
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (!r_ant) begin
                        r_deg0  <= w_deg;
                        r_ant   <= 1'b1;
                        r_lvl   <= (w_os < 4'(OutputSets)) ? m_level[w_os] : 16'sd0;
                        r_state <= ST_MF;
                    end else begin
                        r_wsum  <= r_wsum + 23'(w_w);
                        r_lsum  <= r_lsum + 40'(signed'({1'b0, w_w}) * r_lvl);
                        r_idx   <= r_idx + 7'd1;
                        r_state <= ST_RULE;
                    end
                end
                ST_DIV: begin
                    if (!w_req.start) begin
                        r_res_valid <= 1'b1;
                        r_res_empty <= 1'b1;
                        r_res_value <= '0;
                        r_state     <= ST_IDLE;
                    end else r_state <= ST_QUOT;
                end
                ST_QUOT: begin
                    if (w_rsp.done) begin
                        r_res_valid <= 1'b1;
                        r_res_empty <= 1'b0;
                        r_res_value <= w_rsp.value;
                        r_state     <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_result_valid  = r_res_valid;
    assign o_control_value = r_res_value;
    assign o_no_rule_fired = r_res_empty;

    `ASSERT_IMP(a_result_only_idle, i_clk, i_rst_n, r_res_valid, r_state == ST_IDLE)
    `ASSERT_NEXT(a_div_leads_result, i_clk, i_rst_n, w_rsp.done && r_state == ST_QUOT,
                 r_res_valid && !r_res_empty)
    `ASSERT_IMP(a_index_bound, i_clk, i_rst_n, r_state == ST_RULE, r_idx <= r_n)
endmodule
`default_nettype wire
